FILE: hw/rtl/ula_pkg.sv
// Shared package of the UART line assembler: store size, operation codes,
// command and result item types, back-end state type. No dependencies.
`timescale 1ns / 1ps

package ula_pkg;

	localparam int BUFFER_SIZE = 64;
	localparam int IDX_W       = $clog2(BUFFER_SIZE);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CMP_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [2:0] {
		OP_RX_BYTE  = 3'd0,
		OP_FETCH    = 3'd1,
		OP_RD_READY = 3'd2,
		OP_RD_ACT   = 3'd3,
		OP_RD_OVF   = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
		logic [7:0] max_len;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

	typedef struct packed {
		logic [7:0] line_char;
		logic       last;
		logic       line_ok;
		logic       flag_value;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EMIT
	} back_state_t;

endpackage

FILE: hw/rtl/uart_line_assembler_unit.sv
// UART line assembler, top level. A received byte or a status read is taken
// every cycle while the front queue is not full; a status result is registered
// in the result queue before it shows on the result ports. A fetch reads the line
// store through its one registered read port, a read state and then an emit state
// per character, then emits the terminator. Reset clears the queues, the fill index
// and all flags; the line store is not cleared, and items are taken once reset ends.
`timescale 1ns / 1ps

module uart_line_assembler_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] operation,
	input  logic [7:0] rx_byte,
	input  logic [7:0] max_len,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] line_char,
	output logic       last,
	output logic       line_ok,
	output logic       flag_value
);

	// The front end holds up to two accepted items; operation codes that mean
	// nothing are accepted and dropped there, so the back end only ever sees
	// real work.
	ula_pkg::cmd_chan_t chan;
	logic               cmd_pop;
	logic               res_push;
	logic               res_full;
	ula_pkg::res_t      res;
	ula_pkg::res_t      res_out;

	ula_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.rx_byte   (rx_byte),
		.max_len   (max_len),
		.chan      (chan),
		.cmd_pop   (cmd_pop)
	);

	// The back end owns all state of the line. It works on one item at a
	// time: a fetch keeps it busy until its terminator item is queued, and an
	// item that has a result waits in front of it while the result queue is
	// full.
	ula_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.chan     (chan),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// The result queue decouples the back end from the consumer; a stalled pop holds
	// up received bytes only once the queue is full and a result waits ahead of them.
	ula_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign line_char  = res_out.line_char;
	assign last       = res_out.last;
	assign line_ok    = res_out.line_ok;
	assign flag_value = res_out.flag_value;

	// The back end never offers a result that the queue cannot take.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// The back end only takes a command that the front end holds.
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> chan.valid)
		else $error("command taken from an empty front queue");

	// Every result that is not part of a successful fetch stands alone.
	a_single_results: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !line_ok) |-> last)
		else $error("status or refusal result without last");

	// Fetch results never carry a flag value.
	a_flag_not_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && line_ok) |-> !flag_value)
		else $error("flag value set on a fetch result");

endmodule

FILE: hw/rtl/ula_front.sv
// Front end of the UART line assembler: accepts items, drops unknown operations
// and queues the rest for the back end. Depends on ula_pkg.
`timescale 1ns / 1ps

module ula_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        operation,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        max_len,
	output ula_pkg::cmd_chan_t chan,
	input  logic              cmd_pop
);

	ula_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          known_op;
	logic          do_wr;
	logic          do_rd;

	// Operation codes above the last status read have no effect at all.
	assign known_op = (operation <= 3'(ula_pkg::OP_RD_OVF));
	assign full     = (count_q == 2'd2);
	assign do_wr    = push && !full && known_op;
	assign do_rd    = cmd_pop && (count_q != 2'd0);

	assign chan.valid = (count_q != 2'd0);
	assign chan.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q].op      <= ula_pkg::op_t'(operation);
			entry_q[wr_ptr_q].rx_byte <= rx_byte;
			entry_q[wr_ptr_q].max_len <= max_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/ula_back.sv
// Back end of the UART line assembler: line store, fill index, status flags
// and the fetch sequencer. Depends on ula_pkg.
`timescale 1ns / 1ps

module ula_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ula_pkg::cmd_chan_t chan,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output ula_pkg::res_t      res
);

	logic [7:0]                mem [ula_pkg::BUFFER_SIZE];
	logic [7:0]                rd_data_q;
	logic [ula_pkg::IDX_W-1:0] fill_q;
	logic [ula_pkg::CNT_W-1:0] idx_q;
	logic [7:0]                size_q;
	logic                      ready_q;
	logic                      act_q;
	logic                      ovf_q;
	ula_pkg::back_state_t      state_q;
	ula_pkg::back_state_t      state_d;

	logic                      idle_cmd;
	logic                      is_term;
	logic                      refuse;
	logic                      more_chars;
	logic                      mem_we;
	logic [ula_pkg::IDX_W-1:0] mem_waddr;
	logic [7:0]                mem_wdata;
	logic                      byte_go;
	logic                      fetch_start;
	logic                      fetch_done;
	logic                      clr_ready;
	logic                      clr_act;
	logic                      clr_ovf;

	assign idle_cmd = (state_q == ula_pkg::BK_IDLE) && chan.valid;
	assign is_term  = (chan.cmd.rx_byte == ula_pkg::CH_CR) ||
	                  (chan.cmd.rx_byte == ula_pkg::CH_LF);
	assign refuse   = !ready_q || (chan.cmd.max_len == 8'd0);
	assign more_chars = ((ula_pkg::CMP_W'(idx_q) + ula_pkg::CMP_W'(1)) <
	                     ula_pkg::CMP_W'(size_q)) &&
	                    (idx_q < ula_pkg::CNT_W'(ula_pkg::BUFFER_SIZE)) &&
	                    (rd_data_q != ula_pkg::CH_NUL);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ula_pkg::BK_IDLE: begin
				if (idle_cmd && (chan.cmd.op == ula_pkg::OP_FETCH) && !refuse) begin
					state_d = ula_pkg::BK_READ;
				end
			end
			ula_pkg::BK_READ: begin
				state_d = ula_pkg::BK_EMIT;
			end
			ula_pkg::BK_EMIT: begin
				if (!res_full) begin
					state_d = more_chars ? ula_pkg::BK_READ : ula_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = ula_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res         = '0;
		byte_go     = 1'b0;
		fetch_start = 1'b0;
		fetch_done  = 1'b0;
		clr_ready   = 1'b0;
		clr_act     = 1'b0;
		clr_ovf     = 1'b0;
		unique case (state_q)
			ula_pkg::BK_IDLE: begin
				if (idle_cmd) begin
					unique case (chan.cmd.op)
						ula_pkg::OP_RX_BYTE: begin
							cmd_pop = 1'b1;
							byte_go = 1'b1;
						end
						ula_pkg::OP_FETCH: begin
							if (!refuse) begin
								cmd_pop     = 1'b1;
								fetch_start = 1'b1;
							end else if (!res_full) begin
								cmd_pop  = 1'b1;
								res_push = 1'b1;
								res.last = 1'b1;
							end
						end
						ula_pkg::OP_RD_READY: begin
							if (!res_full) begin
								cmd_pop        = 1'b1;
								res_push       = 1'b1;
								res.last       = 1'b1;
								res.flag_value = ready_q;
								clr_ready      = 1'b1;
							end
						end
						ula_pkg::OP_RD_ACT: begin
							if (!res_full) begin
								cmd_pop        = 1'b1;
								res_push       = 1'b1;
								res.last       = 1'b1;
								res.flag_value = act_q;
								clr_act        = 1'b1;
							end
						end
						ula_pkg::OP_RD_OVF: begin
							if (!res_full) begin
								cmd_pop        = 1'b1;
								res_push       = 1'b1;
								res.last       = 1'b1;
								res.flag_value = ovf_q;
								clr_ovf        = 1'b1;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			ula_pkg::BK_READ: begin
			end
			ula_pkg::BK_EMIT: begin
				if (!res_full) begin
					res_push    = 1'b1;
					res.line_ok = 1'b1;
					if (more_chars) begin
						res.line_char = rd_data_q;
					end else begin
						res.last   = 1'b1;
						fetch_done = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// A received byte is stored only while no finished line is pending.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q;
		mem_wdata = chan.cmd.rx_byte;
		if (byte_go && !ready_q) begin
			if (is_term) begin
				mem_we    = (fill_q != '0);
				mem_wdata = ula_pkg::CH_NUL;
			end else if (fill_q != ula_pkg::IDX_W'(ula_pkg::BUFFER_SIZE - 1)) begin
				mem_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ula_pkg::BK_READ) begin
			rd_data_q <= mem[idx_q[ula_pkg::IDX_W-1:0]];
		end
		if (fetch_start) begin
			size_q <= chan.cmd.max_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ula_pkg::BK_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			ready_q <= 1'b0;
			act_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fetch_start) begin
				idx_q <= '0;
			end else if ((state_q == ula_pkg::BK_EMIT) && res_push && more_chars) begin
				idx_q <= idx_q + ula_pkg::CNT_W'(1);
			end
			if (byte_go) begin
				act_q <= 1'b1;
				if (!ready_q) begin
					if (is_term) begin
						if (fill_q != '0) begin
							ready_q <= 1'b1;
							fill_q  <= '0;
						end
					end else if (fill_q != ula_pkg::IDX_W'(ula_pkg::BUFFER_SIZE - 1)) begin
						fill_q <= fill_q + ula_pkg::IDX_W'(1);
					end else begin
						fill_q <= '0;
						ovf_q  <= 1'b1;
					end
				end
			end
			if (clr_ready || fetch_done) begin
				ready_q <= 1'b0;
			end
			if (clr_act) begin
				act_q <= 1'b0;
			end
			if (clr_ovf) begin
				ovf_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/ula_res_queue.sv
// Two-entry result queue of the UART line assembler, between the back end
// and the result ports. Depends on ula_pkg.
`timescale 1ns / 1ps

module ula_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  ula_pkg::res_t res_in,
	output logic          res_full,
	input  logic          pop,
	output logic          empty,
	output ula_pkg::res_t res_out
);

	ula_pkg::res_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_wr;
	logic          do_rd;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_wr    = res_push && !res_full;
	assign do_rd    = pop && !empty;
	assign res_out  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
